>>> sv/fvn_pkg.sv
// Shared types, constants and register codes for the fractal value-noise block.
`timescale 1ns / 1ps
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int WEIGHT_DEPTH_DEF = 256;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_K1 = 32'd15731;
  localparam logic [31:0] HASH_K2 = 32'd789221;
  localparam logic [31:0] HASH_K3 = 32'd1376312589;
  localparam logic [31:0] HASH_MASK = 32'h7fffffff;

  typedef enum logic [2:0] {
    REG_BASE_FREQ = 3'd0,
    REG_PERSIST   = 3'd1,
    REG_OCTAVES   = 3'd2,
    REG_SEED      = 3'd3,
    REG_MIN       = 3'd4,
    REG_MAX       = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_X,
    S_SCALE_Y,
    S_OCT_SETUP,
    S_HASH_ISSUE,
    S_HASH_WAIT,
    S_BLEND_X0,
    S_BLEND_X1,
    S_BLEND_Y,
    S_ACCUM,
    S_AMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] result;
  } hash_rsp_t;

endpackage

>>> sv/fvn_hash.sv
// Multi-cycle lattice hash over one shared 32x32 wrapping multiplier.
`timescale 1ns / 1ps
module fvn_hash (
  input  logic              clk,
  input  logic              rst,
  input  fvn_pkg::hash_req_t req,
  output fvn_pkg::hash_rsp_t rsp
);

  logic        busy;
  logic [1:0]  phase;
  logic [31:0] n;
  logic [31:0] p;
  logic        done;
  logic [31:0] mix;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;

  assign mix = (req.a + req.b * fvn_pkg::HASH_MUL_Y) ^
               ((req.a + req.b * fvn_pkg::HASH_MUL_Y) << 13);

  always_comb begin
    case (phase)
      2'd0: begin
        mul_a = n;
        mul_b = n;
      end
      2'd1: begin
        mul_a = p;
        mul_b = fvn_pkg::HASH_K1;
      end
      default: begin
        mul_a = n;
        mul_b = p;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          n     <= mix;
          busy  <= 1'b1;
          phase <= 2'd0;
        end
      end else begin
        case (phase)
          2'd0: begin
            p     <= prod;
            phase <= 2'd1;
          end
          2'd1: begin
            p     <= prod + fvn_pkg::HASH_K2;
            phase <= 2'd2;
          end
          default: begin
            p     <= (prod + fvn_pkg::HASH_K3) & fvn_pkg::HASH_MASK;
            busy  <= 1'b0;
            done  <= 1'b1;
            phase <= 2'd0;
          end
        endcase
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = p[30:0];

endmodule

>>> sv/fractal_value_noise.sv
// Top level of the fractal value-noise sampler.
//
// Usage: write the six registers over the APB port while idle, then send
// coordinates on the input channel (in_valid/in_ready, x_coord, y_coord).
// Each transfer yields one sample on the output channel
// (out_valid/out_ready, noise_total, signed Q2.16).
// in_ready is high only while the sequencer is idle; one item is worked at
// a time. After the input transfer the sequencer runs the X and Y scaling
// states, then per octave the setup state, eight lattice hashes on the
// single hash multiplier and five steps on the blend multiplier, then the
// finish state, which waits for the output register to be free. A new item
// is taken only once the sequencer is back in idle.
// The output register holds a finished sample while the receiver stalls;
// the next item can be taken meanwhile, but its result waits until the
// held sample has been taken.
// Synchronous reset returns the configuration registers to their documented
// defaults and drops any item in flight. The weight table is constant logic.
`timescale 1ns / 1ps
module fractal_value_noise #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int WEIGHT_TABLE_DEPTH = fvn_pkg::WEIGHT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        x_coord,
  input  logic [15:0]        y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] noise_total
);

  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int IW = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int PW = 48 + MAX_OCTAVES;

  function automatic logic [16:0] weight_entry(input int unsigned k);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic [63:0]        sq;
    logic signed [63:0] s;
    th   = (fvn_pkg::HALF_PI_Q30 * 64'(k)) / WEIGHT_TABLE_DEPTH;
    th2  = (th * th) >> 30;
    term = th;
    s    = $signed(th);
    term = ((term * th2) >> 30) / 6;
    s    = s - $signed(term);
    term = ((term * th2) >> 30) / 20;
    s    = s + $signed(term);
    term = ((term * th2) >> 30) / 42;
    s    = s - $signed(term);
    term = ((term * th2) >> 30) / 72;
    s    = s + $signed(term);
    term = ((term * th2) >> 30) / 110;
    s    = s - $signed(term);
    term = ((term * th2) >> 30) / 156;
    s    = s + $signed(term);
    term = ((term * th2) >> 30) / 210;
    s    = s - $signed(term);
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    sq = ($unsigned(s) * $unsigned(s) + (64'd1 << 43)) >> 44;
    if (sq > 64'd65536) sq = 64'd65536;
    return sq[16:0];
  endfunction

  logic [16:0] wtab [WEIGHT_TABLE_DEPTH];

  for (genvar k = 0; k < WEIGHT_TABLE_DEPTH; k++) begin : g_wtab
    localparam logic [16:0] W = weight_entry(k);
    assign wtab[k] = W;
  end

  // configuration registers
  logic [23:0]        base_frequency;
  logic [16:0]        persistence;
  logic [3:0]         octave_count;
  logic [31:0]        noise_seed;
  logic signed [17:0] min_total;
  logic signed [17:0] max_total;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= 24'd65536;
      persistence    <= 17'd32768;
      octave_count   <= 4'd4;
      noise_seed     <= 32'd0;
      min_total      <= -18'sd65536;
      max_total      <= 18'sd65536;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        fvn_pkg::REG_BASE_FREQ: base_frequency <= pwdata[23:0];
        fvn_pkg::REG_PERSIST:   persistence    <= pwdata[16:0];
        fvn_pkg::REG_OCTAVES:   octave_count   <= pwdata[3:0];
        fvn_pkg::REG_SEED:      noise_seed     <= pwdata;
        fvn_pkg::REG_MIN:       min_total      <= $signed(pwdata[17:0]);
        fvn_pkg::REG_MAX:       max_total      <= $signed(pwdata[17:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      fvn_pkg::REG_BASE_FREQ: prdata = {8'd0, base_frequency};
      fvn_pkg::REG_PERSIST:   prdata = {15'd0, persistence};
      fvn_pkg::REG_OCTAVES:   prdata = {28'd0, octave_count};
      fvn_pkg::REG_SEED:      prdata = noise_seed;
      fvn_pkg::REG_MIN:       prdata = {14'd0, min_total};
      fvn_pkg::REG_MAX:       prdata = {14'd0, max_total};
      default:                prdata = 32'd0;
    endcase
  end

  // sequencer
  fvn_pkg::state_t state, state_next;
  logic [15:0]        x_reg;
  logic [15:0]        y_reg;
  logic [39:0]        xb;
  logic [39:0]        yb;
  logic [OW-1:0]      octs;
  logic [OW-1:0]      oct;
  logic [31:0]        cx;
  logic [31:0]        cy;
  logic [16:0]        wx;
  logic [16:0]        wy;
  logic [2:0]         hidx;
  logic [30:0]        hres [8];
  logic signed [17:0] i1;
  logic signed [17:0] i2;
  logic signed [17:0] v;
  logic [15:0]        amp;
  logic [16:0]        pers;
  logic signed [19:0] sum;

  fvn_pkg::hash_req_t hreq;
  fvn_pkg::hash_rsp_t hrsp;

  fvn_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  logic [39:0] scale_prod;
  assign scale_prod = (state == fvn_pkg::S_SCALE_X)
                    ? 40'(x_reg) * 40'(base_frequency)
                    : 40'(y_reg) * 40'(base_frequency);

  logic [PW-1:0]      pxs;
  logic [PW-1:0]      pys;
  logic [IW+16:0]     xi_full;
  logic [IW+16:0]     yi_full;
  assign pxs = PW'(xb) << oct;
  assign pys = PW'(yb) << oct;
  assign xi_full = (IW+17)'(pxs[15:0]) * (IW+17)'(WEIGHT_TABLE_DEPTH);
  assign yi_full = (IW+17)'(pys[15:0]) * (IW+17)'(WEIGHT_TABLE_DEPTH);

  // corner values in Q2.16
  logic signed [17:0] c1, c2, c3, c4;
  assign c1 = 18'sd65536 - $signed({1'b0, hres[4][30:14]});
  assign c2 = 18'sd65536 - $signed({1'b0, hres[5][30:14]});
  assign c3 = 18'sd65536 - $signed({1'b0, hres[6][30:14]});
  assign c4 = 18'sd65536 - $signed({1'b0, hres[7][30:14]});

  // shared blend multiplier
  logic signed [19:0] ba;
  logic signed [17:0] bb;
  logic signed [37:0] bprod;
  logic signed [21:0] bsh;

  always_comb begin
    case (state)
      fvn_pkg::S_BLEND_X0: begin
        ba = 20'(c2) - 20'(c1);
        bb = $signed({1'b0, wx});
      end
      fvn_pkg::S_BLEND_X1: begin
        ba = 20'(c4) - 20'(c3);
        bb = $signed({1'b0, wx});
      end
      fvn_pkg::S_BLEND_Y: begin
        ba = 20'(i2) - 20'(i1);
        bb = $signed({1'b0, wy});
      end
      fvn_pkg::S_ACCUM: begin
        ba = 20'(v);
        bb = $signed({2'b0, amp});
      end
      default: begin
        ba = $signed({4'd0, amp});
        bb = $signed({1'b0, pers});
      end
    endcase
  end

  assign bprod = ba * bb;
  assign bsh   = 22'(bprod >>> 16);

  // hash operands by index
  always_comb begin
    hreq.start = (state == fvn_pkg::S_HASH_ISSUE);
    case (hidx)
      3'd0: begin hreq.a = cx;              hreq.b = noise_seed; end
      3'd1: begin hreq.a = cx + 32'd1;      hreq.b = noise_seed; end
      3'd2: begin hreq.a = cy;              hreq.b = noise_seed; end
      3'd3: begin hreq.a = cy + 32'd1;      hreq.b = noise_seed; end
      3'd4: begin hreq.a = {1'b0, hres[0]}; hreq.b = {1'b0, hres[2]}; end
      3'd5: begin hreq.a = {1'b0, hres[1]}; hreq.b = {1'b0, hres[2]}; end
      3'd6: begin hreq.a = {1'b0, hres[0]}; hreq.b = {1'b0, hres[3]}; end
      default: begin hreq.a = {1'b0, hres[1]}; hreq.b = {1'b0, hres[3]}; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      fvn_pkg::S_IDLE:       if (in_valid) state_next = fvn_pkg::S_SCALE_X;
      fvn_pkg::S_SCALE_X:    state_next = fvn_pkg::S_SCALE_Y;
      fvn_pkg::S_SCALE_Y:
        state_next = (octs == '0) ? fvn_pkg::S_FINISH : fvn_pkg::S_OCT_SETUP;
      fvn_pkg::S_OCT_SETUP:  state_next = fvn_pkg::S_HASH_ISSUE;
      fvn_pkg::S_HASH_ISSUE: state_next = fvn_pkg::S_HASH_WAIT;
      fvn_pkg::S_HASH_WAIT:
        if (hrsp.done) begin
          state_next = (hidx == 3'd7) ? fvn_pkg::S_BLEND_X0 : fvn_pkg::S_HASH_ISSUE;
        end
      fvn_pkg::S_BLEND_X0:   state_next = fvn_pkg::S_BLEND_X1;
      fvn_pkg::S_BLEND_X1:   state_next = fvn_pkg::S_BLEND_Y;
      fvn_pkg::S_BLEND_Y:    state_next = fvn_pkg::S_ACCUM;
      fvn_pkg::S_ACCUM:      state_next = fvn_pkg::S_AMP;
      fvn_pkg::S_AMP:
        state_next = (oct + 1'b1 == octs) ? fvn_pkg::S_FINISH : fvn_pkg::S_OCT_SETUP;
      fvn_pkg::S_FINISH:
        if (!out_valid || out_ready) state_next = fvn_pkg::S_IDLE;
      default:               state_next = fvn_pkg::S_IDLE;
    endcase
  end

  assign in_ready = (state == fvn_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fvn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic signed [19:0] lo;
  logic signed [19:0] hi;
  logic signed [17:0] clamped;
  assign lo = 20'(min_total);
  assign hi = 20'(max_total);
  assign clamped = (sum < lo) ? min_total : (sum > hi) ? max_total : sum[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == fvn_pkg::S_FINISH && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        noise_total <= clamped;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fvn_pkg::S_IDLE: begin
        x_reg <= x_coord;
        y_reg <= y_coord;
        oct   <= '0;
        sum   <= '0;
        amp   <= 16'd32768;
        pers  <= (persistence > 17'd65536) ? 17'd65536 : persistence;
        if ({28'd0, octave_count} > MAX_OCTAVES) octs <= OW'(MAX_OCTAVES);
        else octs <= OW'(octave_count);
      end
      fvn_pkg::S_SCALE_X: xb <= scale_prod;
      fvn_pkg::S_SCALE_Y: yb <= scale_prod;
      fvn_pkg::S_OCT_SETUP: begin
        cx   <= pxs[47:16];
        cy   <= pys[47:16];
        wx   <= wtab[xi_full[16 +: IW]];
        wy   <= wtab[yi_full[16 +: IW]];
        hidx <= 3'd0;
      end
      fvn_pkg::S_HASH_WAIT: begin
        if (hrsp.done) begin
          hres[hidx] <= hrsp.result;
          hidx       <= hidx + 3'd1;
        end
      end
      fvn_pkg::S_BLEND_X0: i1 <= 18'(22'(c1) + bsh);
      fvn_pkg::S_BLEND_X1: i2 <= 18'(22'(c3) + bsh);
      fvn_pkg::S_BLEND_Y:  v  <= 18'(22'(i1) + bsh);
      fvn_pkg::S_ACCUM:    sum <= sum + 20'(bsh);
      fvn_pkg::S_AMP: begin
        amp <= bsh[15:0];
        oct <= oct + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/fvn_checker.sv
// Port-level checks for the fractal value-noise block, bound to the top.
`timescale 1ns / 1ps
module fvn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] noise_total
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_total))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after transfer");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after transfer");

endmodule

bind fractal_value_noise fvn_checker u_fvn_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_total (noise_total)
);

>>> sim/fractal_value_noise_tb.sv
// Self-checking testbench for the fractal value-noise sampler.
`timescale 1ns / 1ps
module fractal_value_noise_tb;

  localparam int DEPTH = 256;
  localparam int MAXOCT = 8;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] x_coord = '0, y_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] noise_total;

  fractal_value_noise u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .x_coord(x_coord), .y_coord(y_coord),
    .out_valid(out_valid), .out_ready(out_ready), .noise_total(noise_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers
  logic [23:0] cfg_freq;
  logic [16:0] cfg_pers;
  logic [3:0]  cfg_octs;
  logic [31:0] cfg_seed;
  logic signed [17:0] cfg_min, cfg_max;
  logic [16:0] cos_weight [DEPTH];

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } coord_t;

  coord_t coord_q[$];
  logic signed [17:0] sample_q[$];
  int errors = 0;
  int samples_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  function automatic void build_weights();
    longint unsigned th, th2, term, sq;
    longint s;
    for (int k = 0; k < DEPTH; k++) begin
      th = (64'd1686629713 * k) / DEPTH;
      th2 = (th * th) >> 30;
      term = th;
      s = th;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n & 1) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
      sq = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
      if (sq > 65536) sq = 65536;
      cos_weight[k] = sq[16:0];
    end
  endfunction

  function automatic logic [31:0] mix_hash(logic [31:0] a, logic [31:0] b);
    logic [31:0] n;
    n = a + b * 32'd57;
    n = (n << 13) ^ n;
    return (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
  endfunction

  function automatic longint corner(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = mix_hash(mix_hash(cx, cfg_seed), mix_hash(cy, cfg_seed));
    return 65536 - longint'(h >> 14);
  endfunction

  // floor division by 65536 on signed values
  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint mix_lerp(longint a, longint b, logic [16:0] w);
    return a + floor16((b - a) * longint'(w));
  endfunction

  function automatic logic signed [17:0] noise_sample(coord_t c);
    longint unsigned freq, px, py, amp, pers;
    logic [31:0] cx, cy;
    logic [16:0] wx, wy;
    longint i1, i2, v, sum;
    int octs;
    octs = cfg_octs;
    if (octs > MAXOCT) octs = MAXOCT;
    pers = (cfg_pers > 17'd65536) ? 65536 : cfg_pers;
    amp = 32768;
    sum = 0;
    for (int i = 0; i < octs; i++) begin
      freq = longint'(cfg_freq) << i;
      px = c.x * freq;
      py = c.y * freq;
      cx = px[47:16];
      cy = py[47:16];
      wx = cos_weight[px[15:8]];
      wy = cos_weight[py[15:8]];
      i1 = mix_lerp(corner(cx, cy), corner(cx + 1, cy), wx);
      i2 = mix_lerp(corner(cx, cy + 1), corner(cx + 1, cy + 1), wx);
      v = mix_lerp(i1, i2, wy);
      sum += floor16(v * longint'(amp));
      amp = (amp * pers) >> 16;
    end
    if (sum < cfg_min) return cfg_min;
    else if (sum > cfg_max) return cfg_max;
    return sum[17:0];
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sample_q.push_back(noise_sample('{x: x_coord, y: y_coord}));
        coord_q.pop_front();
      end
      if (in_valid && !in_ready) begin
        // hold until transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (coord_q.size() > ((in_valid && in_ready) ? 0 : 0) &&
                   !(in_valid && in_ready && coord_q.size() == 0)) begin
        if (coord_q.size() > 0) begin
          in_valid <= 1'b1;
          x_coord <= coord_q[0].x;
          y_coord <= coord_q[0].y;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 6);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 30) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 11 != 0);
      if (out_valid && out_ready) begin
        samples_seen <= samples_seen + 1;
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d", $time, noise_total);
          errors <= errors + 1;
        end else begin
          if (noise_total !== sample_q[0]) begin
            $display("%0t: noise_total mismatch, expected %0d, actual %0d",
                     $time, sample_q[0], noise_total);
            errors <= errors + 1;
          end
          sample_q.pop_front();
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(fvn_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      fvn_pkg::REG_BASE_FREQ: cfg_freq = val[23:0];
      fvn_pkg::REG_PERSIST:   cfg_pers = val[16:0];
      fvn_pkg::REG_OCTAVES:   cfg_octs = val[3:0];
      fvn_pkg::REG_SEED:      cfg_seed = val;
      fvn_pkg::REG_MIN:       cfg_min = val[17:0];
      default:                cfg_max = val[17:0];
    endcase
  endtask

  task automatic drain();
    while (coord_q.size() > 0 || in_valid || sample_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic push_coord(logic [15:0] x, logic [15:0] y);
    coord_q.push_back('{x: x, y: y});
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: push_coord(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
        1: push_coord(16'(16'hffff - $urandom_range(0, 15)), 16'($urandom));
        default: push_coord(16'($urandom), 16'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    build_weights();
    cfg_freq = 24'd65536; cfg_pers = 17'd32768; cfg_octs = 4'd4;
    cfg_seed = 32'd0; cfg_min = -18'sd65536; cfg_max = 18'sd65536;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // directed: reset settings, field extremes
    push_coord(16'd0, 16'd0);
    push_coord(16'hffff, 16'hffff);
    push_coord(16'hffff, 16'd0);
    push_coord(16'd0, 16'hffff);
    push_coord(16'h5555, 16'haaaa);
    drain();
    // full range, widest bounds, max frequency so cells wrap
    reg_write(fvn_pkg::REG_BASE_FREQ, 32'hffffff);
    reg_write(fvn_pkg::REG_PERSIST, 32'd65536);
    reg_write(fvn_pkg::REG_OCTAVES, 32'd8);
    reg_write(fvn_pkg::REG_SEED, 32'hffffffff);
    reg_write(fvn_pkg::REG_MIN, 32'h20000);
    reg_write(fvn_pkg::REG_MAX, 32'h1ffff);
    push_coord(16'hffff, 16'hffff);
    push_coord(16'h8001, 16'h7fff);
    push_coord(16'd1, 16'd1);
    drain();
    // persistence above one, octave count above max and zero
    reg_write(fvn_pkg::REG_PERSIST, 32'h1ffff);
    reg_write(fvn_pkg::REG_OCTAVES, 32'd15);
    push_coord(16'd1234, 16'd4321);
    push_coord(16'hfffe, 16'd3);
    drain();
    reg_write(fvn_pkg::REG_OCTAVES, 32'd0);
    reg_write(fvn_pkg::REG_PERSIST, 32'd0);
    push_coord(16'd77, 16'd99);
    drain();
    // crossed bounds
    reg_write(fvn_pkg::REG_OCTAVES, 32'd1);
    reg_write(fvn_pkg::REG_BASE_FREQ, 32'd0);
    reg_write(fvn_pkg::REG_MIN, 32'd1000);
    reg_write(fvn_pkg::REG_MAX, 32'h3ff00);
    push_coord(16'd5, 16'd5);
    push_coord(16'hffff, 16'd0);
    drain();
    // random settings phases
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(fvn_pkg::REG_BASE_FREQ, (ph % 3 == 0) ? $urandom_range(0, 24'hffffff) :
                                        $urandom_range(0, 24'h3ffff));
      reg_write(fvn_pkg::REG_PERSIST, $urandom_range(0, 17'h1ffff));
      reg_write(fvn_pkg::REG_OCTAVES, (ph == 7) ? 8 : $urandom_range(1, 4));
      reg_write(fvn_pkg::REG_SEED, $urandom);
      reg_write(fvn_pkg::REG_MIN, (ph % 4 == 3) ? $urandom_range(0, 18'h3ffff) :
                                  32'h3ffff & -$urandom_range(20000, 131072));
      reg_write(fvn_pkg::REG_MAX, (ph % 4 == 3) ? $urandom_range(0, 18'h3ffff) :
                                  $urandom_range(20000, 131071));
      random_phase((ph == 7) ? 60 : 145);
    end
    $display("Covered %0d samples over directed extremes and eight random register settings.",
             samples_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> fractal_value_noise.f
sv/fvn_pkg.sv
sv/fvn_hash.sv
sv/fractal_value_noise.sv
sv/fvn_checker.sv
sim/fractal_value_noise_tb.sv
